[hdl/lis_pkg.sv]
// ----------------------------------------------------------------------------
// lis_pkg
// Shared types and fixed field widths for the longest increasing subsequence
// core.
// ----------------------------------------------------------------------------
package lis_pkg;

	localparam int OUT_VALUE_W  = 32;
	localparam int OUT_LENGTH_W = 7;

	// Sequencer states, one-hot.
	typedef enum logic [6:0] {
		S_IDLE      = 7'b0000001,
		S_SCAN      = 7'b0000010,
		S_WRITE     = 7'b0000100,
		S_TRACE_RD  = 7'b0001000,
		S_TRACE_WB  = 7'b0010000,
		S_EMIT_RD   = 7'b0100000,
		S_EMIT_SHOW = 7'b1000000
	} lis_state_t;

endpackage

[hdl/lis_ram.sv]
// ----------------------------------------------------------------------------
// lis_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered behind a read enable.
// ----------------------------------------------------------------------------
module lis_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hdl/longest_increasing_subsequence_core.sv]
// ----------------------------------------------------------------------------
// longest_increasing_subsequence_core
// Quadratic dynamic-programming longest strictly increasing subsequence over
// a stream of signed values, with backtracking and in-order output.
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+----------------------------------
//  in      | into core | in_valid/in_stall  | in_value, in_last
//  out     | from core | out_valid/out_stall| out_value, out_length, out_last,
//          |           |                    | out_truncated
//
// An accepted item scans the memories one stored entry per cycle and is then
// written. An item that finds the store full is dropped without stalling. A
// last item then backtracks one link per memory read (S_TRACE_RD, S_TRACE_WB)
// and emits each result through S_EMIT_RD and S_EMIT_SHOW, which waits on any
// output stall.
// Reset clears only the counters and flags; the memories need no clearing.
// The input is stalled from acceptance of an item until its work is done and,
// for a last item, until its final result has been transferred.
// ----------------------------------------------------------------------------
module longest_increasing_subsequence_core #(
	parameter int MAX_ITEMS  = 64,
	parameter int VALUE_BITS = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [lis_pkg::OUT_VALUE_W-1:0]    in_value,
	input  logic                               in_last,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [lis_pkg::OUT_VALUE_W-1:0]    out_value,
	output logic [lis_pkg::OUT_LENGTH_W-1:0]   out_length,
	output logic                               out_last,
	output logic                               out_truncated
);

	import lis_pkg::*;

	localparam int AW = $clog2(MAX_ITEMS);
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int MW = CW + AW;

	lis_state_t              state_q;
	logic [CW-1:0]           count_q;
	logic                    dropped_q;
	logic [CW-1:0]           longest_q;
	logic [AW-1:0]           end_q;
	logic [VALUE_BITS-1:0]   raw_q;
	logic                    last_q;
	logic [CW-1:0]           j_q;
	logic                    pend_s1;
	logic [AW-1:0]           idx_s1;
	logic [CW-1:0]           best_q;
	logic [AW-1:0]           link_q;
	logic [AW-1:0]           k_q;
	logic [AW-1:0]           pos_q;
	logic [AW-1:0]           e_q;
	logic                    out_valid_q;

	logic                    in_xfer;
	logic                    out_xfer;
	logic [VALUE_BITS+31:0]  in_wide;
	logic [VALUE_BITS-1:0]   in_raw;
	logic [AW-1:0]           rd_addr;
	logic                    st_we;
	logic [VALUE_BITS-1:0]   val_rdata;
	logic [MW-1:0]           meta_rdata;
	logic [MW-1:0]           meta_wdata;
	logic [CW-1:0]           len_rdata;
	logic [AW-1:0]           pick_rdata;
	logic [CW-1:0]           cand;
	logic                    cand_ok;
	logic                    new_max;
	logic [CW-1:0]           longest_nx;
	logic [AW-1:0]           end_nx;
	logic [CW-1:0]           last_idx;
	logic [VALUE_BITS+31:0]  val_wide;
	logic                    buf_we;
	logic                    buf_re;
	logic [CW+6:0]           len_wide;

	assign in_stall = (state_q != S_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid_q && !out_stall;

	// Inputs narrower than VALUE_BITS are zero-extended, wider ones cut.
	assign in_wide = {{VALUE_BITS{1'b0}}, in_value};
	assign in_raw  = in_wide[VALUE_BITS-1:0];

	assign rd_addr    = (state_q == S_SCAN) ? j_q[AW-1:0] : pos_q;
	assign st_we      = (state_q == S_WRITE);
	assign meta_wdata = {best_q, link_q};
	assign len_rdata  = meta_rdata[MW-1:AW];
	assign pick_rdata = meta_rdata[AW-1:0];

	assign cand    = len_rdata + CW'(1);
	assign cand_ok = ($signed(val_rdata) < $signed(raw_q)) && (cand >= best_q);

	// Strictly greater keeps the first position of the greatest length.
	assign new_max    = (best_q > longest_q);
	assign longest_nx = new_max ? best_q : longest_q;
	assign end_nx     = new_max ? count_q[AW-1:0] : end_q;
	assign last_idx   = longest_q - CW'(1);

	assign val_wide = {32'b0, val_rdata};
	assign buf_we   = (state_q == S_TRACE_WB);
	assign buf_re   = (state_q == S_EMIT_RD);

	lis_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ITEMS)) u_value_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (count_q[AW-1:0]),
		.wdata (raw_q),
		.re    (1'b1),
		.raddr (rd_addr),
		.rdata (val_rdata)
	);

	lis_ram #(.WIDTH(MW), .DEPTH(MAX_ITEMS)) u_meta_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (count_q[AW-1:0]),
		.wdata (meta_wdata),
		.re    (1'b1),
		.raddr (rd_addr),
		.rdata (meta_rdata)
	);

	// The backtrack runs from the end, so results are staged here and read
	// back in ascending order. The read data is the output value register.
	lis_ram #(.WIDTH(OUT_VALUE_W), .DEPTH(MAX_ITEMS)) u_result_ram (
		.clk   (clk),
		.we    (buf_we),
		.waddr (k_q),
		.wdata (val_wide[OUT_VALUE_W-1:0]),
		.re    (buf_re),
		.raddr (e_q),
		.rdata (out_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			dropped_q   <= 1'b0;
			longest_q   <= '0;
			end_q       <= '0;
			last_q      <= 1'b0;
			j_q         <= '0;
			pend_s1     <= 1'b0;
			k_q         <= '0;
			pos_q       <= '0;
			e_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						last_q <= in_last;
						if (count_q < CW'(MAX_ITEMS)) begin
							state_q <= S_SCAN;
							j_q     <= '0;
							pend_s1 <= 1'b0;
						end else begin
							dropped_q <= 1'b1;
							if (in_last) begin
								state_q <= S_TRACE_RD;
								k_q     <= last_idx[AW-1:0];
								pos_q   <= end_q;
							end
						end
					end
				end
				S_SCAN: begin
					if (j_q < count_q) begin
						j_q     <= j_q + CW'(1);
						pend_s1 <= 1'b1;
					end else begin
						pend_s1 <= 1'b0;
						if (!pend_s1) begin
							state_q <= S_WRITE;
						end
					end
				end
				S_WRITE: begin
					count_q   <= count_q + CW'(1);
					longest_q <= longest_nx;
					end_q     <= end_nx;
					if (last_q) begin
						state_q <= S_TRACE_RD;
						k_q     <= AW'(longest_nx - CW'(1));
						pos_q   <= end_nx;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_TRACE_RD: begin
					state_q <= S_TRACE_WB;
				end
				S_TRACE_WB: begin
					pos_q <= pick_rdata;
					if (k_q == '0) begin
						state_q <= S_EMIT_RD;
						e_q     <= '0;
					end else begin
						k_q     <= k_q - AW'(1);
						state_q <= S_TRACE_RD;
					end
				end
				S_EMIT_RD: begin
					out_valid_q <= 1'b1;
					state_q     <= S_EMIT_SHOW;
				end
				S_EMIT_SHOW: begin
					if (out_xfer) begin
						out_valid_q <= 1'b0;
						if (out_last) begin
							state_q   <= S_IDLE;
							count_q   <= '0;
							dropped_q <= 1'b0;
							longest_q <= '0;
							end_q     <= '0;
						end else begin
							e_q     <= e_q + AW'(1);
							state_q <= S_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Scan datapath: best length and latest qualifying link for the new item.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			raw_q  <= in_raw;
			best_q <= CW'(1);
			link_q <= '0;
		end else if (state_q == S_SCAN) begin
			idx_s1 <= j_q[AW-1:0];
			if (pend_s1 && cand_ok) begin
				best_q <= cand;
				link_q <= idx_s1;
			end
		end
	end

	assign len_wide      = {7'b0, longest_q};
	assign out_valid     = out_valid_q;
	assign out_length    = len_wide[OUT_LENGTH_W-1:0];
	assign out_last      = (e_q == last_idx[AW-1:0]);
	assign out_truncated = dropped_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ITEMS))
		else $error("stored item count exceeds capacity");

	a_longest_bound: assert property (@(posedge clk) disable iff (!arst_n)
		longest_q <= count_q)
		else $error("longest length exceeds stored item count");

	a_best_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRITE) |-> (best_q <= count_q + CW'(1)) && (best_q != '0))
		else $error("computed length out of range");

	a_valid_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (state_q == S_EMIT_SHOW))
		else $error("result shown outside emission");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_xfer && out_last) |=> (count_q == '0) && !dropped_q && (state_q == S_IDLE))
		else $error("sequence state not cleared after final transfer");

endmodule
